// ===== design/adq_pkg.sv =====
package adq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int VALUE_BITS_DEF = 32;

  localparam int VAL_W = 32;
  localparam int OP_W  = 3;
  localparam int ST_W  = 2;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
    logic shift_step;
    logic shift_end;
    logic shift_fin;
    logic read_fr;
    logic out_load;
  } adq_cmd_t;

  typedef struct packed {
    logic need_shift;
    logic shift_last;
    logic out_free;
  } adq_stat_t;

endpackage

// ===== design/adq_ctrl.sv =====
module adq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  adq_pkg::adq_stat_t stat,
  output adq_pkg::adq_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_SHIFT_END,
    S_SHIFT_FIN,
    S_READ,
    S_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.need_shift ? S_SHIFT : S_READ;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (stat.shift_last) begin
          state_nxt = S_SHIFT_END;
        end
      end
      S_SHIFT_END: begin
        cmd.shift_end = 1'b1;
        state_nxt     = S_SHIFT_FIN;
      end
      S_SHIFT_FIN: begin
        cmd.shift_fin = 1'b1;
        state_nxt     = S_READ;
      end
      S_READ: begin
        cmd.read_fr = 1'b1;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/adq_dp.sv =====
module adq_dp #(
  parameter int DEPTH      = adq_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = adq_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  adq_pkg::adq_cmd_t          cmd,
  output adq_pkg::adq_stat_t         stat,
  input  logic [adq_pkg::OP_W-1:0]   in_op,
  input  logic [adq_pkg::VAL_W-1:0]  in_val,
  input  logic                       cfg_wr_en,
  input  logic [adq_pkg::CAP_W-1:0]  cfg_wr_data,
  input  logic                       out_tready,
  output logic                       out_tvalid,
  output logic [103:0]               out_tdata,
  output logic [1:0]                 out_tuser
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CW    = ((IDX_W > adq_pkg::CAP_W) ? IDX_W : adq_pkg::CAP_W) + 1;
  localparam int VW    = adq_pkg::VAL_W;

  logic [adq_pkg::OP_W-1:0]  op_r;
  logic [VALUE_BITS-1:0]     val_r;
  logic [IDX_W-1:0]          front_r;
  logic [IDX_W-1:0]          rear_r;
  logic                      empty_r;
  logic [adq_pkg::CAP_W-1:0] cap_r;
  logic [IDX_W-1:0]          sh_idx_r;
  logic [IDX_W-1:0]          sh_wr_r;
  logic                      sh_pend_r;
  logic [adq_pkg::ST_W-1:0]  status_r;
  logic                      pop_ok_r;
  logic [VW-1:0]             popped_r;
  logic                      out_tvalid_r;
  logic [103:0]              out_tdata_r;
  logic [1:0]                out_tuser_r;

  logic [VALUE_BITS-1:0]     mem [DEPTH];
  logic [VALUE_BITS-1:0]     rdata_a_r;
  logic [VALUE_BITS-1:0]     rdata_b_r;

  logic [VALUE_BITS-1:0]     push_narrow;
  logic [VW-1:0]             rd_a_w;
  logic [VW-1:0]             rd_b_w;

  logic [CW-1:0]             cap_ext;
  logic [CW-1:0]             eff_cap;
  logic [CW-1:0]             rear_inc;
  logic                      full;
  logic                      is_push;
  logic                      is_pop;
  logic                      push_ok;
  logic                      pop_ok;
  logic                      ovf;
  logic                      unf;
  logic                      need_shift;
  logic [IDX_W-1:0]          rear_p1;
  logic [IDX_W-1:0]          front_m1;

  logic                      we;
  logic [IDX_W-1:0]          waddr;
  logic [VALUE_BITS-1:0]     wdata;
  logic                      re_a;
  logic [IDX_W-1:0]          raddr_a;
  logic                      re_b;
  logic [IDX_W-1:0]          raddr_b;

  if (VALUE_BITS <= VW) begin : g_narrow
    assign push_narrow = in_val[VALUE_BITS-1:0];
  end else begin : g_extend
    assign push_narrow = {{(VALUE_BITS-VW){in_val[VW-1]}}, in_val};
  end

  if (VALUE_BITS < VW) begin : g_wsext
    assign rd_a_w = {{(VW-VALUE_BITS){rdata_a_r[VALUE_BITS-1]}}, rdata_a_r};
    assign rd_b_w = {{(VW-VALUE_BITS){rdata_b_r[VALUE_BITS-1]}}, rdata_b_r};
  end else if (VALUE_BITS == VW) begin : g_weq
    assign rd_a_w = rdata_a_r;
    assign rd_b_w = rdata_b_r;
  end else begin : g_wcut
    assign rd_a_w = rdata_a_r[VW-1:0];
    assign rd_b_w = rdata_b_r[VW-1:0];
  end

  assign cap_ext  = CW'(cap_r);
  assign eff_cap  = (cap_r == '0) ? CW'(1) :
                    ((cap_ext > CW'(DEPTH)) ? CW'(DEPTH) : cap_ext);
  assign rear_inc = CW'(rear_r) + CW'(1);
  assign full     = !empty_r && (rear_inc >= eff_cap);
  assign rear_p1  = rear_r + IDX_W'(1);
  assign front_m1 = front_r - IDX_W'(1);

  assign is_push    = (op_r == adq_pkg::OP_PUSH_FRONT) || (op_r == adq_pkg::OP_PUSH_REAR);
  assign is_pop     = (op_r == adq_pkg::OP_POP_FRONT) || (op_r == adq_pkg::OP_POP_REAR);
  assign push_ok    = is_push && !full;
  assign pop_ok     = is_pop && !empty_r;
  assign ovf        = is_push && full;
  assign unf        = is_pop && empty_r;
  assign need_shift = push_ok && !empty_r && (op_r == adq_pkg::OP_PUSH_FRONT) &&
                      (front_r == '0);

  assign stat.need_shift = need_shift;
  assign stat.shift_last = (sh_idx_r == '0);
  assign stat.out_free   = !out_tvalid_r || out_tready;

  always_comb begin
    we      = 1'b0;
    waddr   = '0;
    wdata   = val_r;
    re_a    = 1'b0;
    raddr_a = front_r;
    re_b    = 1'b0;
    raddr_b = rear_r;
    if (cmd.exec && !need_shift) begin
      if (push_ok) begin
        we = 1'b1;
        if (empty_r) begin
          waddr = '0;
        end else if (op_r == adq_pkg::OP_PUSH_REAR) begin
          waddr = rear_p1;
        end else begin
          waddr = front_m1;
        end
      end
      if (pop_ok) begin
        re_a    = 1'b1;
        raddr_a = (op_r == adq_pkg::OP_POP_FRONT) ? front_r : rear_r;
      end
    end
    if (cmd.shift_step) begin
      we      = sh_pend_r;
      waddr   = sh_wr_r;
      wdata   = rdata_a_r;
      re_a    = 1'b1;
      raddr_a = sh_idx_r;
    end
    if (cmd.shift_end) begin
      we    = 1'b1;
      waddr = sh_wr_r;
      wdata = rdata_a_r;
    end
    if (cmd.shift_fin) begin
      we    = 1'b1;
      waddr = '0;
      wdata = val_r;
    end
    if (cmd.read_fr) begin
      re_a    = 1'b1;
      raddr_a = front_r;
      re_b    = 1'b1;
      raddr_b = rear_r;
    end
  end

  // slot store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a_r <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b_r <= mem[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r      <= '0;
      rear_r       <= '0;
      empty_r      <= 1'b1;
      cap_r        <= adq_pkg::CAP_RESET;
      sh_pend_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (cmd.exec) begin
        if (need_shift) begin
          sh_pend_r <= 1'b0;
        end else if (push_ok) begin
          if (empty_r) begin
            front_r <= '0;
            rear_r  <= '0;
            empty_r <= 1'b0;
          end else if (op_r == adq_pkg::OP_PUSH_REAR) begin
            rear_r <= rear_p1;
          end else begin
            front_r <= front_m1;
          end
        end else if (pop_ok) begin
          if (front_r == rear_r) begin
            front_r <= '0;
            rear_r  <= '0;
            empty_r <= 1'b1;
          end else if (op_r == adq_pkg::OP_POP_FRONT) begin
            front_r <= front_r + IDX_W'(1);
          end else begin
            rear_r <= rear_r - IDX_W'(1);
          end
        end
      end
      if (cmd.shift_step) begin
        sh_pend_r <= 1'b1;
      end
      if (cmd.shift_fin) begin
        rear_r <= rear_p1;
      end
      if (cmd.out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      val_r <= push_narrow;
    end
    if (cmd.exec) begin
      status_r <= ovf ? adq_pkg::ST_OVERFLOW : (unf ? adq_pkg::ST_UNDERFLOW : adq_pkg::ST_OK);
      pop_ok_r <= pop_ok;
      if (need_shift) begin
        sh_idx_r <= rear_r;
      end
    end
    if (cmd.shift_step) begin
      sh_wr_r <= sh_idx_r + IDX_W'(1);
      if (sh_idx_r != '0) begin
        sh_idx_r <= sh_idx_r - IDX_W'(1);
      end
    end
    if (cmd.read_fr) begin
      popped_r <= pop_ok_r ? rd_a_w : '1;
    end
    if (cmd.out_load) begin
      out_tuser_r           <= status_r;
      out_tdata_r[31:0]     <= popped_r;
      out_tdata_r[63:32]    <= empty_r ? '1 : rd_a_w;
      out_tdata_r[95:64]    <= empty_r ? '1 : rd_b_w;
      out_tdata_r[96]       <= empty_r;
      out_tdata_r[97]       <= full;
      out_tdata_r[103:98]   <= '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (front_r == '0 && rear_r == '0))
    else $error("empty queue with nonzero index");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    !empty_r |-> (front_r <= rear_r))
    else $error("front index beyond rear index");

  a_ovf_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && ovf) |=> ($stable(front_r) && $stable(rear_r) && $stable(empty_r)))
    else $error("overflow changed queue state");

  a_shift_tail: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_fin |-> (sh_wr_r == IDX_W'(1) && front_r == '0))
    else $error("shift finished before reaching slot one");
`endif

endmodule

// ===== design/array_double_ended_queue.sv =====
// channel   ports       tuser              tdata (low bit up)
// in        in_t*       operation[2:0]     push_value[31:0]
// out       out_t*      status[1:0]        popped_value[31:0], front_value[63:32],
//                                          rear_value[95:64], queue_empty[96],
//                                          queue_full[97], zero[103:98]
// cfg       cfg_wr_*    -                  capacity_in_use[4:0]
//
// Each request runs in order: accept, execute, read front/rear, load result.
// A push at the front with front index 0 into a non-empty queue first moves every
// stored value up one slot, one value per cycle through the single write port.
// rst_n is synchronous; the queue is empty and capacity is 16 after reset.
// A new request is taken while a result waits; a stalled output holds the
// controller before it loads the next result.
module array_double_ended_queue #(
  parameter int DEPTH      = adq_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = adq_pkg::VALUE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // push_value
  input  logic [2:0]   in_tuser,   // operation
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // popped, front, rear, empty, full, pad
  output logic [1:0]   out_tuser,  // status
  input  logic         cfg_wr_en,
  input  logic [4:0]   cfg_wr_data // capacity_in_use
);

  adq_pkg::adq_cmd_t  cmd;
  adq_pkg::adq_stat_t stat;

  adq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  adq_dp #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_op       (in_tuser),
    .in_val      (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule
